/* sv/sic_pkg.sv */
// Shared types and constants for the set intersection core.
`timescale 1ns / 1ps
`default_nettype none
package sic_pkg;

  // Element width of both stores and of the result.
  localparam int unsigned DATA_W = 32;

  // Request kinds carried on the input tuser.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD_A  = 2'd0;
  localparam mode_t MODE_LOAD_B  = 2'd1;
  localparam mode_t MODE_COMPUTE = 2'd2;

  // Bit positions of the flags in the output tuser.
  localparam int unsigned FLAG_EMPTY    = 0;
  localparam int unsigned FLAG_OVERFLOW = 1;

endpackage
`default_nettype wire

/* sv/sic_mem.sv */
// Synchronous one-write one-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sic_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/sic_engine.sv */
// Load and compute sequencer with the result register of the set intersection core.
`timescale 1ns / 1ps
`default_nettype none
module sic_engine #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // request side
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire sic_pkg::mode_t            s_mode_i,
  // result side
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [sic_pkg::DATA_W-1:0]     m_element_o,
  output logic                           m_last_o,
  output logic                           m_empty_o,
  output logic                           m_overflow_o,
  // store A port
  output logic                           a_we_o,
  output logic [AW-1:0]                  a_waddr_o,
  output logic [AW-1:0]                  a_raddr_o,
  input  wire logic [sic_pkg::DATA_W-1:0] a_rdata_i,
  // store B port
  output logic                           b_we_o,
  output logic [AW-1:0]                  b_waddr_o,
  output logic [AW-1:0]                  b_raddr_o,
  input  wire logic [sic_pkg::DATA_W-1:0] b_rdata_i
);
  import sic_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_WAITA,
    S_CMP,
    S_EMIT,
    S_FINISH
  } state_e;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_e              state_q;
  logic [CW-1:0]       cnt_a_q, cnt_b_q;
  logic [CW-1:0]       i_q, j_q;
  logic [CW-1:0]       i_inc, j_inc;
  logic                drop_q;
  logic [DATA_W-1:0]   a_q;
  logic [DATA_W-1:0]   held_q;
  logic                held_v_q;
  logic                out_v_q;
  logic [DATA_W-1:0]   out_data_q;
  logic                out_last_q, out_empty_q, out_ovf_q;
  logic                out_free;
  logic                out_load;
  logic                req;
  logic                a_room, b_room;

  assign req      = s_axis_tvalid_i && (state_q == S_IDLE);
  assign a_room   = cnt_a_q < DEPTH_C;
  assign b_room   = cnt_b_q < DEPTH_C;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign i_inc    = i_q + CW'(1);
  assign j_inc    = j_q + CW'(1);

  // Result register reloads this cycle
  assign out_load = out_free &&
                    (((state_q == S_EMIT) && held_v_q) || (state_q == S_FINISH));

  // Store writes append at the fill count
  assign a_we_o    = req && (s_mode_i == MODE_LOAD_A) && a_room;
  assign b_we_o    = req && (s_mode_i == MODE_LOAD_B) && b_room;
  assign a_waddr_o = cnt_a_q[AW-1:0];
  assign b_waddr_o = cnt_b_q[AW-1:0];

  // Reads: A at the walk index, B at the next scan index
  assign a_raddr_o = i_q[AW-1:0];
  always_comb begin
    case (state_q)
      S_CMP:   b_raddr_o = j_inc[AW-1:0];
      default: b_raddr_o = '0;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_element_o     = out_data_q;
  assign m_last_o        = out_last_q;
  assign m_empty_o       = out_empty_q;
  assign m_overflow_o    = out_ovf_q;

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      a_q         <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_v_q && m_axis_tready_i && !out_load) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req) begin
            case (s_mode_i)
              MODE_LOAD_A: begin
                if (a_room) cnt_a_q <= cnt_a_q + CW'(1);
                else        drop_q  <= 1'b1;
              end
              MODE_LOAD_B: begin
                if (b_room) cnt_b_q <= cnt_b_q + CW'(1);
                else        drop_q  <= 1'b1;
              end
              MODE_COMPUTE: begin
                i_q      <= '0;
                held_v_q <= 1'b0;
                if ((cnt_a_q != '0) && (cnt_b_q != '0)) state_q <= S_RDA;
                else                                    state_q <= S_FINISH;
              end
              default: ;
            endcase
          end
        end
        S_RDA: begin
          state_q <= S_WAITA;
        end
        S_WAITA: begin
          // A element arrives; B[0] read issued now
          a_q     <= a_rdata_i;
          j_q     <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (b_rdata_i == a_q) begin
            state_q <= S_EMIT;
          end else if (j_inc < cnt_b_q) begin
            j_q <= j_inc;
          end else if (i_inc < cnt_a_q) begin
            i_q     <= i_inc;
            state_q <= S_RDA;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_EMIT: begin
          // the previous match goes out, the new one is held for the last mark
          if (!held_v_q || out_free) begin
            if (held_v_q) begin
              out_v_q     <= 1'b1;
              out_data_q  <= held_q;
              out_last_q  <= 1'b0;
              out_empty_q <= 1'b0;
              out_ovf_q   <= drop_q;
            end
            held_q   <= a_q;
            held_v_q <= 1'b1;
            if (i_inc < cnt_a_q) begin
              i_q     <= i_inc;
              state_q <= S_RDA;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_v_q     <= 1'b1;
            out_data_q  <= held_v_q ? held_q : '0;
            out_last_q  <= 1'b1;
            out_empty_q <= !held_v_q;
            out_ovf_q   <= drop_q;
            held_v_q    <= 1'b0;
            cnt_a_q     <= '0;
            cnt_b_q     <= '0;
            drop_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/set_intersection_core.sv */
// Top level of the set intersection core: two value stores and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Loads append a signed 32-bit value to store A or B; a load into a full store
// is dropped and sets the overflow flag. A compute request walks A in load order
// and scans B for each element through the registered read port of each store;
// matches come out in A order, the final one with tlast, and an empty
// intersection gives one result with element 0 and the empty flag. The compute
// clears both counts and the flag. A new request is taken only while the
// sequencer is idle; a finished result may still wait in the output register.
module set_intersection_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] element
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o    // [0] empty_res, [1] overflow
);
  import sic_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              a_we, b_we;
  logic [AW-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;
  logic              m_empty, m_ovf;

  // Stores
  sic_mem #(.DEPTH(DEPTH), .AW(AW), .WIDTH(DATA_W)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  sic_mem #(.DEPTH(DEPTH), .AW(AW), .WIDTH(DATA_W)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Sequencer
  sic_engine #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_mode_i        (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_element_o     (m_axis_tdata_o),
    .m_last_o        (m_axis_tlast_o),
    .m_empty_o       (m_empty),
    .m_overflow_o    (m_ovf),
    .a_we_o          (a_we),
    .a_waddr_o       (a_waddr),
    .a_raddr_o       (a_raddr),
    .a_rdata_i       (a_rdata),
    .b_we_o          (b_we),
    .b_waddr_o       (b_waddr),
    .b_raddr_o       (b_raddr),
    .b_rdata_i       (b_rdata)
  );

  always_comb begin
    m_axis_tuser_o                = '0;
    m_axis_tuser_o[FLAG_EMPTY]    = m_empty;
    m_axis_tuser_o[FLAG_OVERFLOW] = m_ovf;
  end

endmodule
`default_nettype wire

/* sv/sic_checker.sv */
// Port-level checks of the set intersection core and their binding.
`timescale 1ns / 1ps
`default_nettype none
module sic_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic [1:0]  m_axis_tuser_o
);
  import sic_pkg::*;

  // A stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // The empty result is the last of its compute and carries zero
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[FLAG_EMPTY] |->
      m_axis_tlast_o && (m_axis_tdata_o == 32'd0))
    else $error("empty result malformed");

  // A taken compute request leaves the input side busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == MODE_COMPUTE) |=>
      !s_axis_tready_o)
    else $error("request taken during compute");

  // Results only appear out of a compute walk
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result raised outside a compute");

endmodule

bind set_intersection_core sic_checker u_sic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

/* bench/tb_set_intersection_core.sv */
// Testbench for set_intersection_core: stream driver, result monitor and intersection predictor.
`timescale 1ns / 1ps
module tb_set_intersection_core;
  import sic_pkg::*;

  localparam int unsigned DEPTH = 64;
  // Mode 3 is not decoded by the core; used as noise.
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 240;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    mode_t       mode;
    logic [31:0] value;
    bit          drain_first;  // sender waits until all results are in
  } req_t;

  typedef struct {
    logic [31:0] element;
    logic        last;
    logic        is_empty;
    logic        ovf;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value = '0;
  mode_t       in_mode = MODE_LOAD_A;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_element;
  logic        out_last;
  logic [1:0]  out_flags;

  req_t    req_queue[$];
  result_t exp_matches[$];
  int      errors = 0;
  int      live_items = 0;

  // Mirror of the core's stores, counts and drop flag
  logic [31:0] mir_a[DEPTH];
  logic [31:0] mir_b[DEPTH];
  int          cnt_a = 0;
  int          cnt_b = 0;
  bit          lost = 1'b0;

  set_intersection_core #(.DEPTH(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_value),    // [31:0] value
    .s_axis_tuser_i  (in_mode),     // [1:0] mode
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_element), // [31:0] element
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_flags)    // [0] empty_res, [1] overflow
  );

  // Clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Update the mirror for one accepted request and queue the results it causes
  task automatic apply_request(input req_t r);
    result_t found[$];
    result_t res;
    bit hit;
    int i;
    int j;
    case (r.mode)
      MODE_LOAD_A: begin
        if (cnt_a < DEPTH) begin
          mir_a[cnt_a] = r.value;
          cnt_a++;
        end else begin
          lost = 1'b1;
        end
      end
      MODE_LOAD_B: begin
        if (cnt_b < DEPTH) begin
          mir_b[cnt_b] = r.value;
          cnt_b++;
        end else begin
          lost = 1'b1;
        end
      end
      MODE_COMPUTE: begin
        // walk A in load order, keep each element that appears anywhere in B
        for (i = 0; i < cnt_a; i++) begin
          hit = 1'b0;
          for (j = 0; j < cnt_b; j++) begin
            if (mir_b[j] == mir_a[i]) hit = 1'b1;
          end
          if (hit) begin
            res.element  = mir_a[i];
            res.last     = 1'b0;
            res.is_empty = 1'b0;
            res.ovf      = lost;
            found.push_back(res);
          end
        end
        if (found.size() == 0) begin
          res.element  = '0;
          res.last     = 1'b1;
          res.is_empty = 1'b1;
          res.ovf      = lost;
          exp_matches.push_back(res);
        end else begin
          for (i = 0; i < found.size(); i++) begin
            res = found[i];
            res.last = (i == found.size() - 1);
            exp_matches.push_back(res);
          end
        end
        cnt_a = 0;
        cnt_b = 0;
        lost  = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input mode_t mode, input logic [31:0] value, input bit drain);
    req_t r;
    r.mode        = mode;
    r.value       = value;
    r.drain_first = drain;
    req_queue.push_back(r);
    if (mode != MODE_UNUSED) live_items++;
  endtask

  // One random run of loads, usually closed by a compute
  task automatic add_sequence(input int idx);
    logic [31:0] pool[6];
    logic [31:0] v;
    int na;
    int nb;
    int kind;
    int p;
    bit drain;
    bit closed;
    closed = 1'b1;
    kind = $urandom_range(0, 9);
    if (idx == 3) begin
      na = DEPTH + $urandom_range(1, 3);
      nb = $urandom_range(1, 4);
    end else if (idx == 7) begin
      na = $urandom_range(1, 4);
      nb = DEPTH + $urandom_range(1, 3);
    end else if (kind == 0) begin
      // loads left open, they carry over into the next run
      na = $urandom_range(0, 2);
      nb = $urandom_range(0, 2);
      closed = 1'b0;
    end else if (kind == 1) begin
      na = 0;
      nb = 0;
    end else begin
      na = $urandom_range(0, 10);
      nb = $urandom_range(0, 10);
    end
    // small value pool so that matches and duplicates are common
    for (p = 0; p < 6; p++) pool[p] = $urandom();
    if ($urandom_range(0, 3) == 0) pool[0] = 32'h8000_0000;
    if ($urandom_range(0, 3) == 0) pool[1] = 32'h7fff_ffff;
    if ($urandom_range(0, 3) == 0) pool[2] = 32'h0000_0000;
    drain = ($urandom_range(0, 5) == 0);
    while (na > 0 || nb > 0) begin
      v = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)] : $urandom();
      if ($urandom_range(0, 9) == 0) begin
        push_req(MODE_UNUSED, $urandom(), drain);
      end else if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
        push_req(MODE_LOAD_A, v, drain);
        na--;
      end else begin
        push_req(MODE_LOAD_B, v, drain);
        nb--;
      end
      drain = 1'b0;
    end
    if (closed) push_req(MODE_COMPUTE, $urandom(), drain);
  endtask

  // Request driver
  req_t tx_cur;
  int   tx_gap = 0;
  int   tx_phase_left = 0;
  bit   tx_gappy = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) apply_request(tx_cur);
      // alternate between stretches with and without gaps
      if (tx_phase_left == 0) begin
        tx_gappy = $urandom_range(0, 1);
        tx_phase_left = $urandom_range(20, 120);
      end else begin
        tx_phase_left--;
      end
      if (in_valid && !in_ready) begin
        // hold the current request
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0 &&
                   (!req_queue[0].drain_first || exp_matches.size() == 0)) begin
        tx_cur = req_queue.pop_front();
        in_valid <= 1'b1;
        in_value <= tx_cur.value;
        in_mode  <= tx_cur.mode;
        if (tx_gappy && $urandom_range(0, 2) == 0) tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver backpressure
  result_t want;
  int      rx_gap = 0;
  int      rx_hold = 0;
  int      rx_seen = 0;
  int      rx_phase_left = 0;
  bit      rx_gappy = 1'b0;
  bit      rx_long_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_seen++;
        if (exp_matches.size() == 0) begin
          $display("%0t: unexpected result: element %h last %b empty %b overflow %b",
                   $time, out_element, out_last, out_flags[FLAG_EMPTY],
                   out_flags[FLAG_OVERFLOW]);
          errors++;
        end else begin
          want = exp_matches.pop_front();
          if (out_element !== want.element || out_last !== want.last ||
              out_flags[FLAG_EMPTY] !== want.is_empty ||
              out_flags[FLAG_OVERFLOW] !== want.ovf) begin
            $display("%0t: result mismatch: expected element %h last %b empty %b overflow %b",
                     $time, want.element, want.last, want.is_empty, want.ovf);
            $display("%0t:                  actual   element %h last %b empty %b overflow %b",
                     $time, out_element, out_last, out_flags[FLAG_EMPTY],
                     out_flags[FLAG_OVERFLOW]);
            errors++;
          end
        end
      end
      if (rx_phase_left == 0) begin
        rx_gappy = $urandom_range(0, 1);
        rx_phase_left = $urandom_range(20, 120);
      end else begin
        rx_phase_left--;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!rx_long_done && out_valid && !out_last && rx_seen >= 5) begin
        // long hold-off mid-compute so the core stalls its input
        rx_long_done = 1'b1;
        rx_hold = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_gappy && $urandom_range(0, 2) == 0) rx_gap = pick_gap();
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int seq;
    int goal;
    // both stores empty
    push_req(MODE_COMPUTE, 32'h0000_0000, 1'b0);
    // only A loaded, only B loaded
    push_req(MODE_LOAD_A, 32'h8000_0000, 1'b0);
    push_req(MODE_COMPUTE, 32'hffff_ffff, 1'b0);
    push_req(MODE_LOAD_B, 32'h7fff_ffff, 1'b0);
    push_req(MODE_COMPUTE, 32'h0000_0000, 1'b0);
    push_req(MODE_UNUSED, 32'hffff_ffff, 1'b0);
    // extremes with a duplicate in A
    push_req(MODE_LOAD_A, 32'h8000_0000, 1'b0);
    push_req(MODE_LOAD_A, 32'h7fff_ffff, 1'b0);
    push_req(MODE_LOAD_A, 32'h0000_0000, 1'b0);
    push_req(MODE_LOAD_A, 32'hffff_ffff, 1'b0);
    push_req(MODE_LOAD_A, 32'hffff_ffff, 1'b0);
    push_req(MODE_LOAD_B, 32'hffff_ffff, 1'b0);
    push_req(MODE_LOAD_B, 32'h7fff_ffff, 1'b0);
    push_req(MODE_LOAD_B, 32'h0000_0005, 1'b0);
    push_req(MODE_UNUSED, 32'h1234_5678, 1'b0);
    push_req(MODE_COMPUTE, 32'h5555_aaaa, 1'b0);
    // disjoint stores, sent only after the previous results are in
    push_req(MODE_LOAD_A, 32'h0000_0001, 1'b1);
    push_req(MODE_LOAD_B, 32'h0000_0002, 1'b0);
    push_req(MODE_COMPUTE, 32'h0000_0000, 1'b0);
    push_req(MODE_COMPUTE, 32'h0000_0000, 1'b0);

    goal = live_items + RAND_ITEMS;
    seq = 0;
    while (live_items < goal || seq < 8) begin
      add_sequence(seq);
      seq++;
    end
    push_req(MODE_COMPUTE, 32'h0000_0000, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() > 0 || in_valid) @(posedge clk_i);
    while (exp_matches.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
sv/sic_pkg.sv
sv/sic_mem.sv
sv/sic_engine.sv
sv/set_intersection_core.sv
sv/sic_checker.sv
bench/tb_set_intersection_core.sv
